/* design/gre_pkg.sv */
// Shared types, constants and pixel packing for the glyph row color expander.
// No dependencies; imported by every module in the design folder.
package gre_pkg;

    localparam int GLYPH_WIDTH = 8;
    localparam int GLYPH_ROWS  = 16;

    localparam int ADDR_W   = 32;
    localparam int DATA_W   = 32;
    localparam int STRIDE_W = 16;
    localparam int NB_W     = 3;
    localparam int ROW_W    = 4;
    localparam int COL_W    = 3;
    localparam int CFG_W    = 16;
    localparam int ROW_CMP_W = 6;

    localparam logic CFG_ROW_STRIDE  = 1'b0;
    localparam logic CFG_PIXEL_BYTES = 1'b1;

    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 16'd4096;
    localparam logic [NB_W-1:0]     PIXEL_RESET  = 3'd4;

    localparam logic ACT_RAW = 1'b0;
    localparam logic ACT_RGB = 1'b1;

    typedef logic [GLYPH_WIDTH-1:0][ADDR_W-1:0] t_addr_vec;

    typedef struct packed {
        logic [GLYPH_WIDTH-1:0] mask;   // bit c set: column c draws
        logic [DATA_W-1:0]      data;
        logic [NB_W-1:0]        nb;
    } t_item;

    // Clamp the configured pixel size into 1..4.
    function automatic logic [NB_W-1:0] eff_bytes(input logic [NB_W-1:0] pb);
        logic [NB_W-1:0] nb;
        begin
            if (pb == 3'd0) nb = 3'd1;
            else if (pb > 3'd4) nb = 3'd4;
            else nb = pb;
            return nb;
        end
    endfunction

    function automatic logic [DATA_W-1:0] pack_color(
        input logic [NB_W-1:0]   nb,
        input logic              action,
        input logic [DATA_W-1:0] raw,
        input logic [7:0]        r,
        input logic [7:0]        g,
        input logic [7:0]        b
    );
        logic [10:0]       r6;
        logic [10:0]       g6;
        logic [10:0]       b6;
        logic [7:0]        idx;
        logic [DATA_W-1:0] res;
        begin
            r6  = 11'(r) * 11'd6;
            g6  = 11'(g) * 11'd6;
            b6  = 11'(b) * 11'd6;
            idx = 8'(r6[10:8]) + 8'(g6[10:8]) * 8'd6 + 8'(b6[10:8]) * 8'd36;
            res = '0;
            if (action == ACT_RGB) begin
                unique case (nb)
                    3'd1:    res = 32'(idx);
                    3'd2:    res = 32'({r[7:3], g[7:2], b[7:3]});
                    default: res = {8'd0, r, g, b};
                endcase
            end else begin
                unique case (nb)
                    3'd1:    res = {24'd0, raw[7:0]};
                    3'd2:    res = {16'd0, raw[15:0]};
                    3'd3:    res = {8'd0, raw[23:0]};
                    default: res = raw;
                endcase
            end
            return res;
        end
    endfunction

endpackage

/* design/gre_lane.sv */
// One column lane: byte address of a single glyph column on the current line.
// Depends on gre_pkg for widths.
module gre_lane
    import gre_pkg::*;
(
    input  logic [ADDR_W-1:0] i_line,
    input  logic [NB_W-1:0]   i_nb,
    input  logic [COL_W-1:0]  i_col,
    output logic [ADDR_W-1:0] o_addr
);

    logic [COL_W+NB_W-1:0] col_off;

    assign col_off = (COL_W+NB_W)'(i_col) * (COL_W+NB_W)'(i_nb);
    assign o_addr  = i_line + ADDR_W'(col_off);

endmodule

/* design/gre_merge.sv */
// Merging stage: holds the lane addresses of one row and issues one write per
// set column, leftmost first, into an output register. Depends on gre_pkg.
module gre_merge
    import gre_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_a_valid,
    input  t_item             i_a_item,
    input  t_addr_vec         i_addr,
    output logic              o_load,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [ADDR_W-1:0] o_write_address,
    output logic [DATA_W-1:0] o_write_data,
    output logic [NB_W-1:0]   o_write_bytes,
    output logic              o_last_write
);

    logic [GLYPH_WIDTH-1:0] r_mask;
    t_addr_vec              r_addr;
    logic [DATA_W-1:0]      r_data;
    logic [NB_W-1:0]        r_nb;

    logic                   r_o_valid;
    logic [ADDR_W-1:0]      r_o_addr;
    logic [DATA_W-1:0]      r_o_data;
    logic [NB_W-1:0]        r_o_nb;
    logic                   r_o_last;

    logic [GLYPH_WIDTH-1:0] pick;
    logic [GLYPH_WIDTH-1:0] rest;
    logic [ADDR_W-1:0]      sel_addr;
    logic                   out_free;
    logic                   emit;
    logic                   last;

    // Lowest set bit is the leftmost remaining column.
    assign pick     = r_mask & (~r_mask + GLYPH_WIDTH'(1));
    assign rest     = r_mask & ~pick;
    assign last     = (rest == '0);
    assign out_free = !r_o_valid || i_ready;
    assign emit     = (r_mask != '0) && out_free;
    assign o_load   = (r_mask == '0) || (emit && last);

    always_comb begin
        sel_addr = '0;
        for (int c = 0; c < GLYPH_WIDTH; c++) begin
            if (pick[c]) sel_addr = sel_addr | r_addr[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_load) begin
                r_mask <= i_a_valid ? i_a_item.mask : '0;
            end else if (emit) begin
                r_mask <= rest;
            end
            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_addr <= i_addr;
            r_data <= i_a_item.data;
            r_nb   <= i_a_item.nb;
        end
        if (emit) begin
            r_o_addr <= sel_addr;
            r_o_data <= r_data;
            r_o_nb   <= r_nb;
            r_o_last <= last;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_write_address = r_o_addr;
    assign o_write_data    = r_o_data;
    assign o_write_bytes   = r_o_nb;
    assign o_last_write    = r_o_last;

endmodule

/* design/glyph_row_color_expander.sv */
// Color expansion of one monochrome glyph row into framebuffer pixel writes.
// Depends on gre_pkg, gre_lane and gre_merge.
//
// A row word is registered once (line address, packed color, column mask),
// eight column lanes form every pixel address in parallel, and the merging
// stage issues one write per set bit, leftmost column first, through an output
// register. A row with N set bits occupies the merging stage for N writes; a
// row with no set bit, or one that lies outside the glyph, is dropped at the
// input register and produces no write. The next row is taken while the last
// write of the current one is issued, so a steady stream runs at one write per
// cycle unless the output stalls. A row passes the input register, the merge
// mask register and the output register before its first write appears.
module glyph_row_color_expander
    import gre_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_action,
    input  logic [ADDR_W-1:0]   i_glyph_address,
    input  logic [ROW_W-1:0]    i_row_index,
    input  logic [7:0]          i_row_bits,
    input  logic [DATA_W-1:0]   i_raw_color,
    input  logic [7:0]          i_red,
    input  logic [7:0]          i_green,
    input  logic [7:0]          i_blue,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [ADDR_W-1:0]   o_write_address,
    output logic [DATA_W-1:0]   o_write_data,
    output logic [NB_W-1:0]     o_write_bytes,
    output logic                o_last_write
);

    logic [STRIDE_W-1:0]    r_stride;
    logic [NB_W-1:0]        r_pixel_bytes;

    logic                   r_a_valid;
    t_item                  r_a_item;
    logic [ADDR_W-1:0]      r_a_line;

    logic [NB_W-1:0]        nb;
    logic [GLYPH_WIDTH-1:0] n_mask;
    logic                   row_ok;
    logic                   accept;
    logic                   load;
    t_addr_vec              lane_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride      <= STRIDE_RESET;
            r_pixel_bytes <= PIXEL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROW_STRIDE:  r_stride      <= i_cfg_data;
                CFG_PIXEL_BYTES: r_pixel_bytes <= i_cfg_data[NB_W-1:0];
                default: ;
            endcase
        end
    end

    assign nb     = eff_bytes(r_pixel_bytes);
    assign row_ok = (ROW_CMP_W'(i_row_index) < ROW_CMP_W'(GLYPH_ROWS));

    // Reverse the bitmap so bit c is column c.
    always_comb begin
        for (int c = 0; c < GLYPH_WIDTH; c++) begin
            n_mask[c] = i_row_bits[GLYPH_WIDTH-1-c] & row_ok;
        end
    end

    assign o_ready = !r_a_valid || load;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (accept) begin
            // drop rows that draw nothing
            r_a_valid <= (n_mask != '0);
        end else if (load) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_line      <= i_glyph_address
                             + ADDR_W'((ROW_W+STRIDE_W)'(i_row_index)
                                       * (ROW_W+STRIDE_W)'(r_stride));
            r_a_item.mask <= n_mask;
            r_a_item.data <= pack_color(nb, i_action, i_raw_color,
                                        i_red, i_green, i_blue);
            r_a_item.nb   <= nb;
        end
    end

    for (genvar c = 0; c < GLYPH_WIDTH; c++) begin : g_lane
        gre_lane u_lane (
            .i_line (r_a_line),
            .i_nb   (r_a_item.nb),
            .i_col  (COL_W'(c)),
            .o_addr (lane_addr[c])
        );
    end

    gre_merge u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_a_valid       (r_a_valid),
        .i_a_item        (r_a_item),
        .i_addr          (lane_addr),
        .o_load          (load),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_write_address (o_write_address),
        .o_write_data    (o_write_data),
        .o_write_bytes   (o_write_bytes),
        .o_last_write    (o_last_write)
    );

endmodule

/* dv/glyph_row_color_expander_checker.sv */
// Write checker for the glyph row color expander: predicts the framebuffer writes
// of every accepted row word and compares them in order with the block's writes.
// Depends on gre_pkg for widths and register codes.
`timescale 1ns / 100ps
module glyph_row_color_expander_checker
    import gre_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_row_valid,
    input  logic              i_row_ready,
    input  logic              i_action,
    input  logic [ADDR_W-1:0] i_glyph_address,
    input  logic [ROW_W-1:0]  i_row_index,
    input  logic [7:0]        i_row_bits,
    input  logic [DATA_W-1:0] i_raw_color,
    input  logic [7:0]        i_red,
    input  logic [7:0]        i_green,
    input  logic [7:0]        i_blue,
    input  logic              i_wr_valid,
    input  logic              i_wr_ready,
    input  logic [ADDR_W-1:0] i_write_address,
    input  logic [DATA_W-1:0] i_write_data,
    input  logic [NB_W-1:0]   i_write_bytes,
    input  logic              i_last_write,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [NB_W-1:0]   nbytes;
        logic              last;
    } t_pixel_write;

    t_pixel_write        expected_writes[$];
    logic [STRIDE_W-1:0] line_stride;
    logic [NB_W-1:0]     pixel_size;
    int                  mismatches = 0;
    int                  pending_count = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = pending_count;

    task automatic report_error(input string msg);
        if (mismatches < 40) begin
            $display("ERROR at %0t ns: %s", $time, msg);
        end
        mismatches++;
    endtask

    task automatic predict_row_writes();
        logic [NB_W-1:0]   nb;
        logic [DATA_W-1:0] word;
        logic [ADDR_W-1:0] line;
        t_pixel_write      w;
        int                n_set;
        int                k;
        begin
            // Out-of-range pixel sizes fold onto the nearest legal one.
            if (pixel_size == 3'd0) nb = 3'd1;
            else if (pixel_size > 3'd4) nb = 3'd4;
            else nb = pixel_size;

            if (i_action == ACT_RGB) begin
                case (nb)
                    3'd1: word = 32'((int'(i_red) * 6) / 256
                                     + ((int'(i_green) * 6) / 256) * 6
                                     + ((int'(i_blue) * 6) / 256) * 36);
                    3'd2: word = 32'(((int'(i_red) * 32 / 256) << 11)
                                     | ((int'(i_green) * 64 / 256) << 5)
                                     | (int'(i_blue) * 32 / 256));
                    default: word = {8'h00, i_red, i_green, i_blue};
                endcase
            end else if (nb == 3'd4) begin
                word = i_raw_color;
            end else begin
                word = i_raw_color & ((32'd1 << (8 * nb)) - 32'd1);
            end

            line  = i_glyph_address + ADDR_W'(i_row_index) * ADDR_W'(line_stride);
            n_set = $countones(i_row_bits);
            k     = 0;
            if (int'(i_row_index) < GLYPH_ROWS) begin
                for (int col = 0; col < GLYPH_WIDTH; col++) begin
                    if (i_row_bits[GLYPH_WIDTH-1-col]) begin
                        k++;
                        w.addr   = line + ADDR_W'(col) * ADDR_W'(nb);
                        w.data   = word;
                        w.nbytes = nb;
                        w.last   = (k == n_set);
                        expected_writes.push_back(w);
                    end
                end
            end
        end
    endtask

    task automatic check_write();
        t_pixel_write want;
        begin
            if (expected_writes.size() == 0) begin
                report_error($sformatf("write with nothing expected: addr %h data %h",
                                       i_write_address, i_write_data));
            end else begin
                want = expected_writes.pop_front();
                if (i_write_address !== want.addr)
                    report_error($sformatf("write_address %h, expected %h",
                                           i_write_address, want.addr));
                if (i_write_data !== want.data)
                    report_error($sformatf("write_data %h, expected %h at addr %h",
                                           i_write_data, want.data, want.addr));
                if (i_write_bytes !== want.nbytes)
                    report_error($sformatf("write_bytes %0d, expected %0d at addr %h",
                                           i_write_bytes, want.nbytes, want.addr));
                if (i_last_write !== want.last)
                    report_error($sformatf("last_write %b, expected %b at addr %h",
                                           i_last_write, want.last, want.addr));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            line_stride = STRIDE_RESET;
            pixel_size  = PIXEL_RESET;
            expected_writes.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ROW_STRIDE:  line_stride = i_cfg_data[STRIDE_W-1:0];
                    CFG_PIXEL_BYTES: pixel_size  = i_cfg_data[NB_W-1:0];
                endcase
            end
            if (i_row_valid && i_row_ready) predict_row_writes();
            if (i_wr_valid && i_wr_ready) check_write();
        end
        pending_count = expected_writes.size();
    end

endmodule

/* dv/glyph_row_color_expander_test.sv */
// Testbench top for the glyph row color expander: drives row words, format
// registers and write backpressure, and gives the verdict.
// Depends on gre_pkg, the design and glyph_row_color_expander_checker.
`timescale 1ns / 100ps
module glyph_row_color_expander_test;
    import gre_pkg::*;

    localparam int TX_MAX_WAIT           = 11;
    localparam int RX_MAX_WAIT           = 11;
    localparam int SETTLE_CYCLES         = 12;
    localparam int STALL_LIMIT           = 400;
    localparam int PHASES                = 9;
    localparam int RANDOM_ROWS_PER_PHASE = 33;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic              cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    logic              row_valid;
    logic              row_ready;
    logic              action;
    logic [ADDR_W-1:0] glyph_address;
    logic [ROW_W-1:0]  row_index;
    logic [7:0]        row_bits;
    logic [DATA_W-1:0] raw_color;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic              wr_valid;
    logic              wr_ready;
    logic [ADDR_W-1:0] write_address;
    logic [DATA_W-1:0] write_data;
    logic [NB_W-1:0]   write_bytes;
    logic              last_write;

    int fail_count;
    int pending_writes;
    int idle_cycles = 0;
    int next_gap    = 0;
    bit tx_quiet    = 1'b0;
    bit rx_quiet    = 1'b0;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    glyph_row_color_expander uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_valid         (row_valid),
        .o_ready         (row_ready),
        .i_action        (action),
        .i_glyph_address (glyph_address),
        .i_row_index     (row_index),
        .i_row_bits      (row_bits),
        .i_raw_color     (raw_color),
        .i_red           (red),
        .i_green         (green),
        .i_blue          (blue),
        .o_valid         (wr_valid),
        .i_ready         (wr_ready),
        .o_write_address (write_address),
        .o_write_data    (write_data),
        .o_write_bytes   (write_bytes),
        .o_last_write    (last_write)
    );

    glyph_row_color_expander_checker write_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_row_valid     (row_valid),
        .i_row_ready     (row_ready),
        .i_action        (action),
        .i_glyph_address (glyph_address),
        .i_row_index     (row_index),
        .i_row_bits      (row_bits),
        .i_raw_color     (raw_color),
        .i_red           (red),
        .i_green         (green),
        .i_blue          (blue),
        .i_wr_valid      (wr_valid),
        .i_wr_ready      (wr_ready),
        .i_write_address (write_address),
        .i_write_data    (write_data),
        .i_write_bytes   (write_bytes),
        .i_last_write    (last_write),
        .o_fail_count    (fail_count),
        .o_pending       (pending_writes)
    );

    // End the run when neither channel nor the register port moves for too long.
    always @(posedge clk) begin
        if (!rst_n || cfg_we || (row_valid && row_ready) || (wr_valid && wr_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Write sink: stall a random number of cycles before taking each word.
    initial begin
        int stall;
        wr_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            stall = rx_quiet ? 0 : $urandom_range(0, RX_MAX_WAIT);
            if (stall > 0) begin
                wr_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            wr_ready <= 1'b1;
            do @(posedge clk); while (!wr_valid);
        end
    end

    function automatic logic [7:0] color_byte();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Keep valid high into the next word when no gap follows.
    task automatic send_row(input logic act, input logic [ADDR_W-1:0] addr,
                            input logic [ROW_W-1:0] row, input logic [7:0] bits,
                            input logic [DATA_W-1:0] raw, input logic [7:0] r,
                            input logic [7:0] g, input logic [7:0] b);
        repeat (next_gap) @(posedge clk);
        row_valid     <= 1'b1;
        action        <= act;
        glyph_address <= addr;
        row_index     <= row;
        row_bits      <= bits;
        raw_color     <= raw;
        red           <= r;
        green         <= g;
        blue          <= b;
        do @(posedge clk); while (!row_ready);
        next_gap = tx_quiet ? 0 : $urandom_range(0, TX_MAX_WAIT);
        if (next_gap > 0) row_valid <= 1'b0;
    endtask

    task automatic send_random_row();
        logic [ADDR_W-1:0] addr;
        logic [7:0]        bits;
        begin
            case ($urandom_range(0, 3))
                0:       addr = 32'hFFFF_FFFF - $urandom_range(0, 255);
                1:       addr = $urandom_range(0, 255);
                default: addr = $urandom;
            endcase
            case ($urandom_range(0, 9))
                0:       bits = 8'hFF;
                1:       bits = 8'h01 << $urandom_range(0, 7);
                2:       bits = 8'h00;
                default: bits = 8'($urandom);
            endcase
            send_row(1'($urandom_range(0, 1)), addr, ROW_W'($urandom_range(0, 15)), bits,
                     $urandom, color_byte(), color_byte(), color_byte());
        end
    endtask

    // Drop valid and hold until every expected write is out, then let the pipe empty.
    task automatic finish_burst();
        if (next_gap == 0) begin
            row_valid <= 1'b0;
            next_gap = 1;
        end
        @(posedge clk);
        while (pending_writes != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_format(input logic [STRIDE_W-1:0] stride,
                              input logic [CFG_W-1:0] pixel_word);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ROW_STRIDE;
        cfg_data  <= CFG_W'(stride);
        @(posedge clk);
        cfg_index <= CFG_PIXEL_BYTES;
        cfg_data  <= pixel_word;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_ROW_STRIDE;
        cfg_data      <= '0;
        row_valid     <= 1'b0;
        action        <= ACT_RAW;
        glyph_address <= '0;
        row_index     <= '0;
        row_bits      <= '0;
        raw_color     <= '0;
        red           <= '0;
        green         <= '0;
        blue          <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset format: stride 4096, four bytes per pixel.
        send_row(ACT_RAW, 32'h0000_0000, 4'd0, 8'hFF, 32'hFFFF_FFFF, 8'h00, 8'h00, 8'h00);
        send_row(ACT_RGB, 32'hFFFF_FFFF, 4'd15, 8'h80, 32'h0000_0000, 8'hFF, 8'hFF, 8'hFF);
        send_row(ACT_RGB, 32'hFFFF_F000, 4'd15, 8'h01, 32'hFFFF_FFFF, 8'h00, 8'h00, 8'h00);
        // empty row: no write
        send_row(ACT_RAW, 32'h1234_5678, 4'd7, 8'h00, 32'h1234_5678, 8'h12, 8'h34, 8'h56);
        send_row(ACT_RAW, 32'h8000_0000, 4'd1, 8'hAA, 32'hA5A5_5A5A, 8'hFF, 8'h00, 8'hFF);
        send_row(ACT_RGB, 32'h0000_1000, 4'd8, 8'h55, 32'h0000_0000, 8'h80, 8'h7F, 8'h01);
        send_row(ACT_RGB, 32'hFFFF_FFF8, 4'd15, 8'h81, 32'h0000_0001, 8'h2A, 8'hD5, 8'h2B);

        for (int phase = 0; phase < PHASES; phase++) begin
            logic [STRIDE_W-1:0] stride;
            logic [CFG_W-1:0]    pixel_word;
            finish_burst();
            case (phase)
                0: begin stride = 16'd0;     pixel_word = 16'd1; end
                1: begin stride = 16'hFFFF;  pixel_word = 16'd2; end
                2: begin stride = 16'd1;     pixel_word = 16'd3; end
                3: begin stride = 16'd4096;  pixel_word = 16'd0; end
                4: begin
                    stride     = 16'($urandom_range(1, 65535));
                    pixel_word = 16'd5;
                end
                5: begin
                    stride     = 16'($urandom);
                    pixel_word = {13'($urandom), 3'd7};
                end
                6: begin
                    stride     = 16'($urandom);
                    pixel_word = {13'h1FFF, 3'd6};
                end
                7: begin
                    stride     = 16'($urandom);
                    pixel_word = 16'($urandom);
                end
                default: begin stride = 16'hFFFF;  pixel_word = 16'd4; end
            endcase
            set_format(stride, pixel_word);
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);

            send_row(ACT_RGB, 32'hFFFF_FFFC, 4'd15, 8'hFF, $urandom, 8'hFF, 8'hFF, 8'hFF);
            send_row(ACT_RAW, $urandom, 4'd0, 8'hC3, 32'hFFFF_FFFF, 8'h00, 8'h00, 8'h00);
            repeat (RANDOM_ROWS_PER_PHASE) begin
                send_random_row();
                if ($urandom_range(0, 24) == 0) finish_burst();
            end
        end

        finish_burst();
        if (fail_count == 0 && pending_writes == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
